>>> rtl/pump_torque_reserve_ramp_assert.svh
// Assertion macros used by the checker file of the torque reserve ramp.
`ifndef PUMP_TORQUE_RESERVE_RAMP_ASSERT_SVH
`define PUMP_TORQUE_RESERVE_RAMP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PTRR_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ptrr check failed");

// Consequence that must hold at the clock edge after the antecedent.
`define PTRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptrr check failed");

`endif

>>> rtl/ptrr_pkg.sv
// Types, constants and helper functions of the pump torque reserve ramp.
`default_nettype none
package ptrr_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RES_W = 11;
  localparam int unsigned UP_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TIME = 3'd5;

  localparam logic [RES_W-1:0] DELAY_CAP   = 11'd1500;
  localparam logic [RES_W-1:0] RESERVE_CAP = 11'd1600;

  // ceil(2^21 / 25); exact quotient for every 16-bit dividend.
  localparam logic [16:0] DIV25_MUL = 17'd83887;

  typedef struct packed {
    logic [15:0] vehicle_speed;
    logic        pump_halt;
    logic        speed_fault;
    logic [15:0] idle_reserve;
  } ptrr_in_t;

  typedef struct packed {
    logic [RES_W-1:0] reserve_torque;
    logic             speed_ok;
    logic             delay_ok;
    logic             reserve_active;
  } ptrr_out_t;

  // Settings as the step logic uses them; the rate steps are pre-divided.
  typedef struct packed {
    logic             enable;
    logic [7:0]       speed_threshold;
    logic [15:0]      target_torque;
    logic [UP_W-1:0]  up_step;
    logic [RES_W-1:0] down_step;
    logic [RES_W-1:0] delay_load;
  } ptrr_cfg_t;

  function automatic logic [UP_W-1:0] div25(input logic [15:0] x);
    logic [32:0] prod;
    prod = {17'd0, x} * {16'd0, DIV25_MUL};
    return prod[32:21];
  endfunction

  // Decrease step from the signed fall limit; positive limits give zero.
  function automatic logic [RES_W-1:0] fall_step(input logic [15:0] lim);
    logic [15:0]     mag;
    logic [UP_W-1:0] q;
    mag = lim[15] ? (~lim + 16'd1) : 16'd0;
    q = div25(mag);
    return q[RES_W-1:0];
  endfunction

  // Turn-on delay in ticks: delay * 25 / 4, capped.
  function automatic logic [RES_W-1:0] delay_ticks(input logic [7:0] d);
    logic [12:0]      prod;
    logic [RES_W-1:0] q;
    prod = {1'b0, d, 4'd0} + {2'b0, d, 3'd0} + {5'd0, d};
    q = prod[12:2];
    return (q < DELAY_CAP) ? q : DELAY_CAP;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ptrr_core.sv
// State registers and single-tick update of the torque reserve ramp.
`default_nettype none
module ptrr_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire ptrr_pkg::ptrr_cfg_t cfg,
  input  wire ptrr_pkg::ptrr_in_t  item,
  output ptrr_pkg::ptrr_out_t      res
);
  import ptrr_pkg::*;

  logic [RES_W-1:0] reserve_r, reserve_nxt;
  logic             active_before_r, active_before_nxt;
  logic             halt_before_r, halt_before_nxt;
  logic [RES_W-1:0] delay_cnt_r, delay_cnt_nxt;
  logic [2:0]       held_r, held_nxt;

  logic             speed_ok;
  logic             delay_ok;
  logic             active;
  logic [RES_W-1:0] cnt_lim;
  logic [15:0]      tgt;
  logic [15:0]      cur;
  logic [15:0]      diff;
  logic [15:0]      up16;
  logic [15:0]      down16;
  logic [16:0]      val;

  always_comb begin
    reserve_nxt       = reserve_r;
    active_before_nxt = active_before_r;
    halt_before_nxt   = halt_before_r;
    delay_cnt_nxt     = delay_cnt_r;
    held_nxt          = held_r;

    cnt_lim = (delay_cnt_r < DELAY_CAP) ? delay_cnt_r : DELAY_CAP;
    if (item.pump_halt) begin
      if (!halt_before_r) begin
        delay_cnt_nxt = cfg.delay_load;
      end else if (delay_cnt_r != '0) begin
        delay_cnt_nxt = cnt_lim - 11'd1;
      end
      delay_ok = (delay_cnt_nxt != '0);
    end else begin
      delay_ok = 1'b1;
    end

    speed_ok = (item.vehicle_speed < {3'd0, cfg.speed_threshold, 5'd0}) || item.speed_fault;
    active   = item.pump_halt && delay_ok && speed_ok;

    tgt    = active ? cfg.target_torque : 16'd0;
    cur    = {5'd0, reserve_r};
    up16   = {4'd0, cfg.up_step};
    down16 = {5'd0, cfg.down_step};

    // Slew toward the target, except on the first active tick which seeds.
    if (active && !active_before_r) begin
      val  = {1'b0, item.idle_reserve};
      diff = '0;
    end else if (tgt > cur) begin
      diff = tgt - cur;
      val  = {1'b0, cur} + {1'b0, (diff < up16) ? diff : up16};
    end else begin
      diff = cur - tgt;
      val  = {1'b0, cur - ((diff < down16) ? diff : down16)};
    end

    if (cfg.enable) begin
      reserve_nxt       = (val < {6'd0, RESERVE_CAP}) ? val[RES_W-1:0] : RESERVE_CAP;
      active_before_nxt = active;
      halt_before_nxt   = item.pump_halt;
      held_nxt          = {active, delay_ok, speed_ok};
    end else begin
      delay_cnt_nxt = delay_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserve_r       <= '0;
      active_before_r <= 1'b0;
      halt_before_r   <= 1'b0;
      delay_cnt_r     <= '0;
      held_r          <= '0;
    end else if (step_en) begin
      reserve_r       <= reserve_nxt;
      active_before_r <= active_before_nxt;
      halt_before_r   <= halt_before_nxt;
      delay_cnt_r     <= delay_cnt_nxt;
      held_r          <= held_nxt;
    end
  end

  always_comb begin
    res.reserve_torque = reserve_nxt;
    res.speed_ok       = held_nxt[0];
    res.delay_ok       = held_nxt[1];
    res.reserve_active = held_nxt[2];
  end

endmodule
`default_nettype wire

>>> rtl/pump_torque_reserve_ramp.sv
// A result is registered in the output register, or in the skid register while the output stalls.
// Throughput: one request per cycle while in_stall is low; the state update is a single registered step.
// A two-entry output buffer lets a request enter while one result waits downstream.
// Reset (synchronous, active low) clears all settings, the ramp state and the buffer's valid flags.
`default_nettype none
module pump_torque_reserve_ramp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ptrr_pkg::ptrr_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ptrr_pkg::ptrr_out_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ptrr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ptrr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ptrr_pkg::*;

  ptrr_cfg_t cfg_r;
  ptrr_out_t res;
  ptrr_out_t out_data_r;
  ptrr_out_t skid_data_r;
  logic      out_valid_r;
  logic      skid_valid_r;
  logic      accept;
  logic      out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:     cfg_r.enable          <= cfg_data[0];
        CFG_SPEED_THR:  cfg_r.speed_threshold <= cfg_data[7:0];
        CFG_TARGET:     cfg_r.target_torque   <= cfg_data;
        CFG_RISE_LIMIT: cfg_r.up_step         <= div25(cfg_data);
        CFG_FALL_LIMIT: cfg_r.down_step       <= fall_step(cfg_data);
        CFG_DELAY_TIME: cfg_r.delay_load      <= delay_ticks(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  ptrr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .cfg     (cfg_r),
    .item    (in_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= res;
      end
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/ptrr_chk.sv
// Port-level checker for the torque reserve ramp, bound to the top level.
`default_nettype none
`include "pump_torque_reserve_ramp_assert.svh"
module ptrr_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ptrr_pkg::ptrr_out_t out_data
);
  import ptrr_pkg::*;

  // The ramp output never leaves its clamp.
  `PTRR_ASSERT_NOW(a_reserve_cap, !out_valid || (out_data.reserve_torque <= RESERVE_CAP))

  // An active reserve requires both the speed and delay conditions.
  `PTRR_ASSERT_NOW(a_active_flags,
    !out_valid || !out_data.reserve_active || (out_data.speed_ok && out_data.delay_ok))

  // A result held back by the consumer stays put.
  `PTRR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Every request that enters is followed by out_valid high in the next cycle.
  `PTRR_ASSERT_NEXT(a_in_to_out, in_valid && !in_stall, out_valid)

endmodule

bind pump_torque_reserve_ramp ptrr_chk u_ptrr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
